@@ rtl/core/sjf_pkg.sv @@
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types and constants of the shortest-job-first scheduler: job and
// result records, the controller command and datapath status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package sjf_pkg;

  localparam int unsigned MAX_JOBS = 16;
  localparam int unsigned IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int unsigned ID_W     = 8;
  localparam int unsigned ARR_W    = 16;
  localparam int unsigned BURST_W  = 12;
  localparam int unsigned TIME_W   = 18;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [ARR_W-1:0]   arrive_at;
    logic [BURST_W-1:0] burst_len;
    logic               final_job;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] idle_total;
    logic [TIME_W-1:0] end_time;
    logic              last_result;
  } result_t;

  // one stored table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrive;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic jump;
    logic emit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pick_found;
    logic last_job;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sjf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sjf_ctrl
// Sequencer of the scheduler: loading, table scans, idle jumps and result
// issue, driving the datapath by command signals.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               final_job_i,
  input  wire sjf_pkg::dp_status_t status_i,
  output sjf_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_JUMP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (final_job_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = status_i.pick_found ? ST_EMIT : ST_JUMP;
        end
      end
      ST_JUMP: begin
        // nothing arrived yet: move the clock on and look again
        cmd_o.jump       = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.last_job) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/sjf_dp.sv @@
// ----------------------------------------------------------------------------
// sjf_dp
// Datapath of the scheduler: job table memory, scan trackers for the best
// ready job and the earliest pending arrival, clock and idle counters, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sjf_pkg::job_t       job_i,
  input  wire sjf_pkg::ctrl_cmd_t  cmd_i,
  output sjf_pkg::dp_status_t      status_o,
  output sjf_pkg::result_t         result_o,
  output logic                     result_valid_o
);

  localparam int unsigned IDX_W  = sjf_pkg::IDX_W;
  localparam int unsigned CNT_W  = sjf_pkg::CNT_W;
  localparam int unsigned TIME_W = sjf_pkg::TIME_W;
  localparam int unsigned ARR_W  = sjf_pkg::ARR_W;

  sjf_pkg::entry_t mem [sjf_pkg::MAX_JOBS];

  logic [CNT_W-1:0]             count_q;
  logic [CNT_W-1:0]             scan_q;
  logic [CNT_W-1:0]             done_cnt_q;
  logic [sjf_pkg::MAX_JOBS-1:0] done_q;
  logic [TIME_W-1:0]            clock_q;
  logic [TIME_W-1:0]            idle_q;

  logic                         rd_vld_q;
  logic [IDX_W-1:0]             rd_idx_q;
  sjf_pkg::entry_t              rd_data_q;

  logic                         pick_vld_q;
  logic [IDX_W-1:0]             pick_idx_q;
  sjf_pkg::entry_t              pick_q;
  logic                         earl_vld_q;
  logic [ARR_W-1:0]             earl_arr_q;

  sjf_pkg::result_t             result_q, result_d;
  logic                         valid_q;

  logic                         table_full;
  logic                         issue;
  logic                         arrived;
  logic                         better;
  logic                         earlier;
  logic                         last_job;
  logic [TIME_W-1:0]            fin;

  assign table_full = (count_q == CNT_W'(sjf_pkg::MAX_JOBS));
  assign issue      = cmd_i.scan_step && (scan_q != count_q);

  // table write on load, registered read during a scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !table_full) begin
      mem[count_q[IDX_W-1:0]] <= '{id:     job_i.job_id,
                                   arrive: job_i.arrive_at,
                                   burst:  job_i.burst_len};
    end
    if (issue) begin
      rd_data_q <= mem[scan_q[IDX_W-1:0]];
    end
  end

  assign arrived = ({{(TIME_W-ARR_W){1'b0}}, rd_data_q.arrive} <= clock_q);
  // shorter burst wins, then lower id; equal keys keep the earlier entry
  assign better  = !pick_vld_q || (rd_data_q.burst < pick_q.burst) ||
                   ((rd_data_q.burst == pick_q.burst) && (rd_data_q.id < pick_q.id));
  assign earlier = !earl_vld_q || (rd_data_q.arrive < earl_arr_q);

  assign last_job = ((done_cnt_q + CNT_W'(1)) == count_q);
  assign fin      = clock_q + TIME_W'(pick_q.burst);

  always_comb begin
    result_d             = '0;
    result_d.done_id     = pick_q.id;
    result_d.start_time  = clock_q;
    result_d.finish_time = fin;
    result_d.turnaround  = fin - TIME_W'(pick_q.arrive);
    result_d.waiting     = clock_q - TIME_W'(pick_q.arrive);
    if (last_job) begin
      result_d.idle_total  = idle_q;
      result_d.end_time    = fin;
      result_d.last_result = 1'b1;
    end
  end

  // trackers and payload registers
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !done_q[rd_idx_q] && arrived && better) begin
      pick_idx_q <= rd_idx_q;
      pick_q     <= rd_data_q;
    end
    if (rd_vld_q && !done_q[rd_idx_q] && earlier) begin
      earl_arr_q <= rd_data_q.arrive;
    end
    if (cmd_i.emit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_q     <= '0;
      done_cnt_q <= '0;
      done_q     <= '0;
      clock_q    <= '0;
      idle_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      pick_vld_q <= 1'b0;
      earl_vld_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q  <= cmd_i.emit;
      rd_vld_q <= issue;
      if (issue) begin
        rd_idx_q <= scan_q[IDX_W-1:0];
        scan_q   <= scan_q + CNT_W'(1);
      end
      if (cmd_i.load && !table_full) begin
        count_q                     <= count_q + CNT_W'(1);
        done_q[count_q[IDX_W-1:0]] <= 1'b0;
      end
      if (rd_vld_q && !done_q[rd_idx_q]) begin
        if (arrived && better) begin
          pick_vld_q <= 1'b1;
        end
        if (earlier) begin
          earl_vld_q <= 1'b1;
        end
      end
      if (cmd_i.jump) begin
        idle_q  <= idle_q + ({{(TIME_W-ARR_W){1'b0}}, earl_arr_q} - clock_q);
        clock_q <= {{(TIME_W-ARR_W){1'b0}}, earl_arr_q};
      end
      if (cmd_i.emit && !cmd_i.clear) begin
        done_q[pick_idx_q] <= 1'b1;
        clock_q            <= fin;
        done_cnt_q         <= done_cnt_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        scan_q     <= '0;
        pick_vld_q <= 1'b0;
        earl_vld_q <= 1'b0;
      end
      // schedule complete: back to the empty state
      if (cmd_i.clear) begin
        count_q    <= '0;
        done_cnt_q <= '0;
        done_q     <= '0;
        clock_q    <= '0;
        idle_q     <= '0;
      end
    end
  end

  assign status_o.scan_done  = (scan_q == count_q) && !rd_vld_q;
  assign status_o.pick_found = pick_vld_q;
  assign status_o.last_job   = last_job;

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/sjf_nonpreemptive_scheduler.sv @@
// Loading takes one job per cycle while busy is low; the job with final_job set
// starts the schedule and busy stays high until the last result is issued.
// Each result needs a scan of the n-entry table through its registered read
// port, and a second scan when the clock must first jump to the next arrival;
// the strobe is registered and comes in the cycle after the dispatch, never held off.
// Reset clears the table count, done marks, clock and idle count at once.
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler: loads a set of jobs, then
// issues one result per stored job in completion order.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_nonpreemptive_scheduler (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire sjf_pkg::job_t    job_i,
  output logic                  busy,
  output sjf_pkg::result_t      result_o,
  output logic                  result_valid_o
);

  sjf_pkg::ctrl_cmd_t  cmd;
  sjf_pkg::dp_status_t status;

  sjf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .final_job_i (job_i.final_job),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  sjf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // a result only follows a dispatch while the schedule runs
  a_result_in_schedule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe outside a schedule");

  // the final job of a set starts the schedule
  a_final_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && job_i.final_job) |=> busy)
    else $error("final job did not start the schedule");

  // the last result ends the schedule
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |-> !busy)
    else $error("still busy after the last result");

  // finish minus start equals turnaround minus waiting by construction of the result
  a_times_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.finish_time - result_o.start_time ==
                        result_o.turnaround - result_o.waiting))
    else $error("result times inconsistent");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads job sets into the shortest-job-first scheduler and checks every
// completion against an in-bench prediction of the schedule: a directed
// table first (extremes, zero burst, tie-breaks, a full table), then random
// sets of mixed density with random gaps on the job side.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned MAX_JOBS      = sjf_pkg::MAX_JOBS;
  localparam int unsigned ID_W          = sjf_pkg::ID_W;
  localparam int unsigned ARR_W         = sjf_pkg::ARR_W;
  localparam int unsigned BURST_W       = sjf_pkg::BURST_W;
  localparam int unsigned TIME_W        = sjf_pkg::TIME_W;

  localparam int unsigned RANDOM_ITEMS  = 430;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct {
    sjf_pkg::job_t    job;
    bit               typed;
    sjf_pkg::result_t want;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  sjf_pkg::job_t    job_i;
  logic             busy;
  sjf_pkg::result_t result_o;
  logic             result_valid_o;

  sjf_nonpreemptive_scheduler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .job_i          (job_i),
    .busy           (busy),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // scheduler image held by the bench
  logic [ID_W-1:0]    tbl_id    [MAX_JOBS];
  logic [ARR_W-1:0]   tbl_arr   [MAX_JOBS];
  logic [BURST_W-1:0] tbl_burst [MAX_JOBS];
  int unsigned        tbl_fill;

  sjf_pkg::result_t completions_due[$];
  sjf_pkg::result_t schedule_q[$];
  plan_row_t        plan[$];
  bit               typed_active;
  sjf_pkg::result_t typed_want;

  int unsigned errors;
  int unsigned jobs_loaded;
  int unsigned jobs_dropped;
  int unsigned schedules_run;
  int unsigned completions_seen;
  int unsigned idle_cycles;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit runs_ahead(int unsigned a, int unsigned b);
    if (tbl_burst[a] != tbl_burst[b]) return tbl_burst[a] < tbl_burst[b];
    if (tbl_id[a] != tbl_id[b]) return tbl_id[a] < tbl_id[b];
    return a < b;
  endfunction

  // walks the held table in completion order into schedule_q
  function automatic void predict_schedule();
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] tat;
    bit                finished [MAX_JOBS];
    bit                any_ready;
    int unsigned       pick;
    int unsigned       first;
    sjf_pkg::result_t  r;
    schedule_q.delete();
    now  = '0;
    idle = '0;
    foreach (finished[i]) finished[i] = 1'b0;
    for (int unsigned k = 0; k < tbl_fill; k++) begin
      first     = tbl_fill;
      any_ready = 1'b0;
      for (int unsigned i = 0; i < tbl_fill; i++) begin
        if (!finished[i]) begin
          if (first == tbl_fill || tbl_arr[i] < tbl_arr[first]) first = i;
          if (TIME_W'(tbl_arr[i]) <= now) any_ready = 1'b1;
        end
      end
      // nothing waiting: jump to the earliest arrival and count the gap
      if (!any_ready) begin
        idle = idle + (TIME_W'(tbl_arr[first]) - now);
        now  = TIME_W'(tbl_arr[first]);
      end
      pick = tbl_fill;
      for (int unsigned i = 0; i < tbl_fill; i++) begin
        if (!finished[i] && TIME_W'(tbl_arr[i]) <= now &&
            (pick == tbl_fill || runs_ahead(i, pick))) pick = i;
      end
      fin           = now + TIME_W'(tbl_burst[pick]);
      tat           = fin - TIME_W'(tbl_arr[pick]);
      r.done_id     = tbl_id[pick];
      r.start_time  = now;
      r.finish_time = fin;
      r.turnaround  = tat;
      r.waiting     = tat - TIME_W'(tbl_burst[pick]);
      r.last_result = (k + 1 == tbl_fill);
      r.idle_total  = r.last_result ? idle : '0;
      r.end_time    = r.last_result ? fin : '0;
      finished[pick] = 1'b1;
      now = fin;
      schedule_q.insert(schedule_q.size(), r);
    end
  endfunction

  function automatic void take_job(sjf_pkg::job_t j);
    jobs_loaded++;
    if (tbl_fill < MAX_JOBS) begin
      tbl_id[tbl_fill]    = j.job_id;
      tbl_arr[tbl_fill]   = j.arrive_at;
      tbl_burst[tbl_fill] = j.burst_len;
      tbl_fill++;
    end else begin
      jobs_dropped++;
    end
    if (j.final_job) begin
      schedules_run++;
      predict_schedule();
      tbl_fill = 0;
      if (typed_active) begin
        completions_due.insert(completions_due.size(), typed_want);
      end else begin
        foreach (schedule_q[i]) completions_due.insert(completions_due.size(), schedule_q[i]);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_completion(sjf_pkg::result_t got);
    sjf_pkg::result_t want;
    if (completions_due.size() == 0) begin
      $error("completion for job %0d with none outstanding", got.done_id);
      errors++;
    end else begin
      want = completions_due.pop_front();
      check_field("done_id",     TIME_W'(want.done_id),     TIME_W'(got.done_id));
      check_field("start_time",  want.start_time,           got.start_time);
      check_field("finish_time", want.finish_time,          got.finish_time);
      check_field("turnaround",  want.turnaround,           got.turnaround);
      check_field("waiting",     want.waiting,              got.waiting);
      check_field("idle_total",  want.idle_total,           got.idle_total);
      check_field("end_time",    want.end_time,             got.end_time);
      check_field("last_result", TIME_W'(want.last_result), TIME_W'(got.last_result));
      completions_seen++;
    end
  endfunction

  // completions first: the last one may share an edge with the next job
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1) check_completion(result_o);
      if (start === 1'b1 && busy === 1'b0) take_job(job_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start === 1'b1 && busy === 1'b0) || result_valid_o === 1'b1) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_job(sjf_pkg::job_t j, int unsigned gap, bit typed,
                          sjf_pkg::result_t want);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_active = typed;
    typed_want   = want;
    start <= 1'b1;
    job_i <= j;
    do @(posedge clk_i); while (!(start === 1'b1 && busy === 1'b0));
  endtask

  function automatic void add_row(logic [ID_W-1:0] id, logic [ARR_W-1:0] arr,
                                  logic [BURST_W-1:0] bl, logic fin,
                                  bit typed, sjf_pkg::result_t want);
    plan_row_t row;
    row.job   = '{job_id: id, arrive_at: arr, burst_len: bl, final_job: fin};
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  initial begin
    sjf_pkg::job_t j;
    int unsigned   sent;
    int unsigned   set_len;
    int unsigned   mode;
    int unsigned   roll;
    bit            quiet;
    bit            narrow_ids;

    rst_ni       = 1'b0;
    start        = 1'b0;
    job_i        = '0;
    typed_active = 1'b0;
    typed_want   = '0;
    tbl_fill     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // lone jobs at the field extremes, and a zero burst
    add_row(8'hff, 16'h0000, 12'h001, 1'b1, 1'b1,
            '{done_id: 8'hff, start_time: 0, finish_time: 1, turnaround: 1,
              waiting: 0, idle_total: 0, end_time: 1, last_result: 1'b1});
    add_row(8'h00, 16'hffff, 12'hfff, 1'b1, 1'b1,
            '{done_id: 8'h00, start_time: 65535, finish_time: 69630,
              turnaround: 4095, waiting: 0, idle_total: 65535, end_time: 69630,
              last_result: 1'b1});
    add_row(8'h5a, 16'd10, 12'h000, 1'b1, 1'b1,
            '{done_id: 8'h5a, start_time: 10, finish_time: 10, turnaround: 0,
              waiting: 0, idle_total: 10, end_time: 10, last_result: 1'b1});
    // equal burst and id: the entry loaded first goes first, then a gap
    add_row(8'd3, 16'd5,   12'd8, 1'b0, 1'b0, '0);
    add_row(8'd3, 16'd0,   12'd8, 1'b0, 1'b0, '0);
    add_row(8'd9, 16'd0,   12'd6, 1'b0, 1'b0, '0);
    add_row(8'd1, 16'd100, 12'd5, 1'b1, 1'b0, '0);
    // full table: one plain job and then the final one are both dropped
    for (int unsigned i = 0; i < MAX_JOBS + 2; i++) begin
      add_row(ID_W'(i * 29 + 7), ARR_W'(i * 3001), BURST_W'(4095 - i * 200),
              i == MAX_JOBS + 1, 1'b0, '0);
    end

    foreach (plan[i]) send_job(plan[i].job, pick_gap(1'b0), plan[i].typed, plan[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) set_len = $urandom_range(1, 8);
      else if (roll < 92) set_len = $urandom_range(9, MAX_JOBS);
      else set_len = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      mode       = $urandom_range(0, 3);
      quiet      = ($urandom_range(0, 3) == 0);
      narrow_ids = ($urandom_range(0, 2) == 0);
      for (int unsigned i = 0; i < set_len; i++) begin
        j.job_id = narrow_ids ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom_range(0, 255));
        case (mode)
          0: begin
            // dense: many jobs ready at once, lots of ties
            j.arrive_at = ARR_W'($urandom_range(0, set_len * 6));
            j.burst_len = BURST_W'($urandom_range(1, 16));
          end
          1: begin
            j.arrive_at = ARR_W'($urandom_range(0, 65535));
            j.burst_len = BURST_W'($urandom_range(1, 4095));
          end
          2: begin
            j.arrive_at = ARR_W'(65535 - $urandom_range(0, 200));
            j.burst_len = BURST_W'($urandom_range(1, 300));
          end
          default: begin
            j.arrive_at = ARR_W'($urandom_range(0, 2000));
            j.burst_len = BURST_W'($urandom_range(1, 200));
          end
        endcase
        j.final_job = (i + 1 == set_len);
        send_job(j, pick_gap(quiet), 1'b0, '0);
        sent++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (completions_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d jobs loaded over %0d schedules, %0d dropped on a full table",
             jobs_loaded, schedules_run, jobs_dropped);
    $display("tb: %0d completions checked, %0d mismatches", completions_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sjf_pkg.sv
rtl/core/sjf_ctrl.sv
rtl/core/sjf_dp.sv
rtl/core/sjf_nonpreemptive_scheduler.sv
tb/testbench.sv
